// File: hw/rtl/ssdl_pkg.sv
// ----------------------------------------------------------------------------
// ssdl_pkg
// Shared types, command bytes and segment patterns for the display link.
// ----------------------------------------------------------------------------
package ssdl_pkg;

    localparam int DIGITS    = 4;
    localparam int FRAME_LEN = 2 + DIGITS;

    localparam logic [7:0] CMD_DATA   = 8'h40;
    localparam logic [7:0] CMD_ADDR   = 8'hC0;
    localparam logic [7:0] CMD_BRIGHT = 8'h87;
    localparam logic [7:0] SEG_MINUS  = 8'h40;
    localparam logic [7:0] SEG_BLANK  = 8'h00;
    localparam logic [7:0] SEP_BIT    = 8'h80;
    localparam logic [3:0] BRIGHT_MAX = 4'd8;

    typedef enum logic [1:0] {
        MODE_DEC    = 2'd0,
        MODE_HEX    = 2'd1,
        MODE_TWO    = 2'd2,
        MODE_BRIGHT = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [15:0]       value;
        logic              separator;
        logic signed [7:0] left_number;
        logic signed [7:0] right_number;
        logic [3:0]        brightness_level;
    } req_t;

    // one output beat with its framing marks
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
        logic       last;
    } beat_t;

    typedef beat_t [FRAME_LEN-1:0] frame_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'h0: pat = 8'h3f;
            4'h1: pat = 8'h06;
            4'h2: pat = 8'h5b;
            4'h3: pat = 8'h4f;
            4'h4: pat = 8'h66;
            4'h5: pat = 8'h6d;
            4'h6: pat = 8'h7d;
            4'h7: pat = 8'h07;
            4'h8: pat = 8'h7f;
            4'h9: pat = 8'h6f;
            4'hA: pat = 8'h77;
            4'hB: pat = 8'h7c;
            4'hC: pat = 8'h39;
            4'hD: pat = 8'h5e;
            4'hE: pat = 8'h79;
            default: pat = 8'h71;
        endcase
        return pat;
    endfunction

endpackage

// File: hw/rtl/seven_segment_display_link.sv
// ----------------------------------------------------------------------------
// seven_segment_display_link
// Display request in, framed byte list for a four-digit segment driver out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  request | in        | in_valid / in_stall | mode, value, separator,
//          |           |                     | left_number, right_number,
//          |           |                     | brightness_level
//  byte    | out       | out_valid/out_stall | data_byte, frame_start,
//          |           |                     | frame_end, last
//
//  A display request gives six output beats, a brightness request one; with
//  no stall the byte port runs one beat per cycle, and the byte shift
//  register takes the next request as the last beat of its list goes out.
//  A taken request passes the input register, then the byte shift register.
//  One request waits in the input register while the previous list drains.
//  rst_n clears only the two valid flags; payload registers are not reset.
//  A stall on the byte side holds the current beat and, once the input
//  register is full, raises in_stall.
//
module seven_segment_display_link (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        mode,
    input  logic [15:0]       value,
    input  logic              separator,
    input  logic signed [7:0] left_number,
    input  logic signed [7:0] right_number,
    input  logic [3:0]        brightness_level,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        data_byte,
    output logic              frame_start,
    output logic              frame_end,
    output logic              last
);

    // input register
    logic             req_valid_reg;
    logic             req_valid_next;
    ssdl_pkg::req_t   req_reg;

    // byte shift register, beat 0 faces the port
    logic             buf_valid_reg;
    logic             buf_valid_next;
    ssdl_pkg::frame_t buf_reg;
    ssdl_pkg::frame_t buf_next;

    ssdl_pkg::frame_t enc_frame;

    logic in_fire;
    logic out_fire;
    logic buf_done;
    logic buf_load;

    ssdl_encode u_encode (
        .req   (req_reg),
        .frame (enc_frame)
    );

    assign out_fire = buf_valid_reg && !out_stall;
    assign buf_done = out_fire && buf_reg[0].last;
    // move the waiting request on once the list ahead of it has gone out
    assign buf_load = req_valid_reg && (!buf_valid_reg || buf_done);
    assign in_stall = req_valid_reg && !buf_load;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_fire)
            req_valid_next = 1'b1;
        else if (buf_load)
            req_valid_next = 1'b0;
    end

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        buf_next       = buf_reg;
        if (buf_load)
        begin
            buf_valid_next = 1'b1;
            buf_next       = enc_frame;
        end
        else if (out_fire)
        begin
            buf_valid_next = !buf_reg[0].last;
            for (int i = 0; i < ssdl_pkg::FRAME_LEN - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            buf_next[ssdl_pkg::FRAME_LEN-1] = buf_reg[ssdl_pkg::FRAME_LEN-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            buf_valid_reg <= buf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= '{mode: ssdl_pkg::mode_t'(mode), value: value,
                         separator: separator, left_number: left_number,
                         right_number: right_number,
                         brightness_level: brightness_level};
        end
        buf_reg <= buf_next;
    end

    assign out_valid   = buf_valid_reg;
    assign data_byte   = buf_reg[0].data_byte;
    assign frame_start = buf_reg[0].frame_start;
    assign frame_end   = buf_reg[0].frame_end;
    assign last        = buf_reg[0].last;

endmodule

// File: hw/rtl/ssdl_encode.sv
// ----------------------------------------------------------------------------
// ssdl_encode
// Turns one display request into the full beat list of its transfer.
// ----------------------------------------------------------------------------
module ssdl_encode (
    input  ssdl_pkg::req_t   req,
    output ssdl_pkg::frame_t frame
);

    // decimal split: v/10^k by reciprocal multiply, exact over 16 bits
    logic [32:0] prod1;
    logic [32:0] prod2;
    logic [32:0] prod3;
    logic [32:0] prod4;
    logic [12:0] q1;
    logic [9:0]  q2;
    logic [6:0]  q3;
    logic [2:0]  q4;
    logic [15:0] r0;
    logic [12:0] r1;
    logic [9:0]  r2;
    logic [6:0]  r3;
    logic [3:0]  dec_dig [ssdl_pkg::DIGITS];

    // two-number halves
    logic [7:0] lo_l;
    logic [7:0] hi_l;
    logic [7:0] lo_r;
    logic [7:0] hi_r;
    logic [7:0] dig     [ssdl_pkg::DIGITS];
    logic [3:0] lvl;
    logic [7:0] bright_byte;

    assign prod1 = {17'd0, req.value} * 33'd52429;   // >>19 : /10
    assign prod2 = {17'd0, req.value} * 33'd83887;   // >>23 : /100
    assign prod3 = {17'd0, req.value} * 33'd67109;   // >>26 : /1000
    assign prod4 = {17'd0, req.value} * 33'd107375;  // >>30 : /10000

    assign q1 = prod1[31:19];
    assign q2 = prod2[32:23];
    assign q3 = prod3[32:26];
    assign q4 = prod4[32:30];

    assign r0 = req.value - ({q1, 3'b000} + {2'b00, q1, 1'b0});
    assign r1 = q1 - 13'({q2, 3'b000} + {q2, 1'b0});
    assign r2 = q2 - 10'({q3, 3'b000} + {q3, 1'b0});
    assign r3 = q3 - 7'({q4, 3'b000} + {q4, 1'b0});

    assign dec_dig[0] = r0[3:0];
    assign dec_dig[1] = r1[3:0];
    assign dec_dig[2] = r2[3:0];
    assign dec_dig[3] = r3[3:0];

    function automatic logic [15:0] two_digit(input logic [7:0] raw);
        logic        neg;
        logic [7:0]  mag;
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  rem;
        logic [3:0]  tens;
        logic [7:0]  hi;
        neg  = raw[7];
        mag  = neg ? (8'd0 - raw) : raw;
        prod = {8'd0, mag} * 16'd205;              // >>11 : /10 for mag <= 128
        q    = prod[14:11];
        rem  = mag - ({1'b0, q, 3'b000} + {3'b000, q, 1'b0});
        tens = (q >= 4'd10) ? (q - 4'd10) : q;
        if (neg)
            hi = ssdl_pkg::SEG_MINUS;
        else if (mag > 8'd9)
            hi = ssdl_pkg::seg_pattern(tens);
        else
            hi = ssdl_pkg::SEG_BLANK;
        return {hi, ssdl_pkg::seg_pattern(rem[3:0])};
    endfunction

    assign {hi_l, lo_l} = two_digit(req.left_number);
    assign {hi_r, lo_r} = two_digit(req.right_number);

    always_comb
    begin
        unique case (req.mode) inside
            ssdl_pkg::MODE_DEC:
            begin
                for (int i = 0; i < ssdl_pkg::DIGITS; i++)
                begin
                    dig[i] = ssdl_pkg::seg_pattern(dec_dig[i]);
                end
            end
            ssdl_pkg::MODE_TWO:
            begin
                dig[0] = lo_l;
                dig[1] = hi_l;
                dig[2] = lo_r;
                dig[3] = hi_r;
            end
            ssdl_pkg::MODE_HEX, ssdl_pkg::MODE_BRIGHT:
            begin
                for (int i = 0; i < ssdl_pkg::DIGITS; i++)
                begin
                    dig[i] = ssdl_pkg::seg_pattern(req.value[4*i +: 4]);
                end
            end
        endcase
        if (req.separator && (req.mode != ssdl_pkg::MODE_TWO))
            dig[2] = dig[2] | ssdl_pkg::SEP_BIT;
    end

    assign lvl = (req.brightness_level > ssdl_pkg::BRIGHT_MAX) ?
                 ssdl_pkg::BRIGHT_MAX : req.brightness_level;
    assign bright_byte = ssdl_pkg::CMD_BRIGHT + {4'd0, lvl};

    always_comb
    begin
        frame[0] = '{data_byte: ssdl_pkg::CMD_DATA, frame_start: 1'b1,
                     frame_end: 1'b1, last: 1'b0};
        frame[1] = '{data_byte: ssdl_pkg::CMD_ADDR, frame_start: 1'b1,
                     frame_end: 1'b0, last: 1'b0};
        for (int i = 0; i < ssdl_pkg::DIGITS; i++)
        begin
            frame[2+i] = '{data_byte: dig[ssdl_pkg::DIGITS-1-i], frame_start: 1'b0,
                           frame_end: (i == ssdl_pkg::DIGITS-1),
                           last: (i == ssdl_pkg::DIGITS-1)};
        end
        // brightness is a one-byte transfer; the rest of the list is unused
        if (req.mode == ssdl_pkg::MODE_BRIGHT)
            frame[0] = '{data_byte: bright_byte, frame_start: 1'b1,
                         frame_end: 1'b1, last: 1'b1};
    end

endmodule

// File: hw/rtl/ssdl_checker.sv
// ----------------------------------------------------------------------------
// ssdl_checker
// Port-level checks on the byte channel of the display link.
// ----------------------------------------------------------------------------
module ssdl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data_byte,
    input logic       frame_start,
    input logic       frame_end,
    input logic       last
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) &&
        $stable(frame_start) && $stable(frame_end) && $stable(last))
        else $error("byte beat changed under stall");

    // final beat always closes a frame
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_end)
        else $error("last beat without stop");

    // an open frame starts with the address command
    a_addr_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_start && !frame_end |-> data_byte == ssdl_pkg::CMD_ADDR)
        else $error("open frame not led by address command");

    // the whole list is buffered, so the beat after the data command follows at once
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_start && frame_end && !last |=>
        out_valid && frame_start && !frame_end)
        else $error("gap or bad beat after data command");

endmodule

bind seven_segment_display_link ssdl_checker u_ssdl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .frame_end   (frame_end),
    .last        (last)
);
